// ----- hw/rtl/skvt_pkg.sv -----
// Shared types and codes for the sorted key/value table.
package skvt_pkg;

    localparam int VALUE_W  = 32;
    localparam int KEY_MAXW = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } skvt_ctl_t;

endpackage

// ----- hw/rtl/skvt_cell.sv -----
// One slot of the table: holds a key and a value and shifts with its neighbors.
module skvt_cell #(
    parameter int KEY_W = 64
) (
    input  logic                       clk,
    input  skvt_pkg::skvt_ctl_t        ctl,
    input  logic [KEY_W-1:0]           key_in,
    input  logic [skvt_pkg::VALUE_W-1:0] value_in,
    input  logic                       occupied,
    input  logic                       left_below,
    input  logic [KEY_W-1:0]           left_key,
    input  logic [skvt_pkg::VALUE_W-1:0] left_value,
    input  logic [KEY_W-1:0]           right_key,
    input  logic [skvt_pkg::VALUE_W-1:0] right_value,
    output logic [KEY_W-1:0]           key,
    output logic [skvt_pkg::VALUE_W-1:0] value,
    output logic                       below,
    output logic                       hit
);
    import skvt_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    assign key   = key_reg;
    assign value = value_reg;
    assign below = occupied && (key_reg < key_in);
    assign hit   = occupied && (key_reg == key_in);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.ins && !below)
        begin
            // first slot not below the key takes the new entry, the rest move up
            if (left_below)
            begin
                key_next   = key_in;
                value_next = value_in;
            end
            else
            begin
                key_next   = left_key;
                value_next = left_value;
            end
        end
        else if (ctl.rem && !below)
        begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ----- hw/rtl/skvt_chain.sv -----
// Row of table cells with match reduction and value select.
module skvt_chain #(
    parameter int CAPACITY = 64,
    parameter int KEY_W    = 64,
    parameter int CNT_W    = 7
) (
    input  logic                         clk,
    input  skvt_pkg::skvt_ctl_t          ctl,
    input  logic [KEY_W-1:0]             key_in,
    input  logic [skvt_pkg::VALUE_W-1:0] value_in,
    input  logic [CNT_W-1:0]             count,
    output logic                         hit,
    output logic [skvt_pkg::VALUE_W-1:0] value_out
);
    import skvt_pkg::*;

    logic [KEY_W-1:0]   cell_key   [CAPACITY];
    logic [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_below;
    logic [CAPACITY-1:0] cell_hit;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic               occ;
            logic               lb;
            logic [KEY_W-1:0]   lk;
            logic [VALUE_W-1:0] lv;
            logic [KEY_W-1:0]   rk;
            logic [VALUE_W-1:0] rv;

            assign occ = 32'(count) > 32'(gi);

            if (gi == 0)
            begin : g_head
                assign lb = 1'b1;
                assign lk = key_in;
                assign lv = value_in;
            end
            else
            begin : g_body
                assign lb = cell_below[gi-1];
                assign lk = cell_key[gi-1];
                assign lv = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rk = cell_key[gi];
                assign rv = cell_value[gi];
            end
            else
            begin : g_mid
                assign rk = cell_key[gi+1];
                assign rv = cell_value[gi+1];
            end

            skvt_cell #(
                .KEY_W(KEY_W)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .key_in     (key_in),
                .value_in   (value_in),
                .occupied   (occ),
                .left_below (lb),
                .left_key   (lk),
                .left_value (lv),
                .right_key  (rk),
                .right_value(rv),
                .key        (cell_key[gi]),
                .value      (cell_value[gi]),
                .below      (cell_below[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    assign hit = |cell_hit;

    // keys are unique, so at most one cell matches
    always_comb
    begin
        value_out = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_hit[i])
            begin
                value_out = value_out | cell_value[i];
            end
        end
    end

endmodule

// ----- hw/rtl/sorted_key_value_table.sv -----
// Top level of the sorted key/value table: stream ports, control and result register.
//
// The table holds up to CAPACITY key/value entries in ascending key order in a row of cells,
// one entry per cell. A word on the slave side carries a command (insert, remove, lookup), a
// key of up to KEY_BYTES bytes (first character in the most significant used byte, cut at the
// first zero byte) and a value. Every word gives exactly one result word: a status (done or
// found, not found, duplicate key, table full, empty key), the value found by a lookup (zero
// otherwise) and the entry count after the operation. A word is first captured with its key
// cleaned up, then executed: every cell compares its key against it in parallel and
// the whole row shifts up (insert) or down (remove) by one cell. The result waits in an output
// register, and the next word is taken while it waits; the row stalls only when a second result
// is ready and the first has not been taken. The stored entries come up undefined after reset
// and are never read before written; only count, state and output valid are cleared.
module sorted_key_value_table #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // command[1:0], key[65:2], value[97:66], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata    // status[2:0], value_out[34:3], count[41:35], zero pad
);
    import skvt_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [KEY_MAXW-1:0]  raw_key;
    logic [KEY_W-1:0]     norm_key;
    logic                 accept;
    logic                 go;
    logic                 empty_key;
    logic                 full;
    logic                 hit;
    logic [VALUE_W-1:0]   hit_value;
    status_t              status;
    logic [VALUE_W-1:0]   result_value;
    skvt_ctl_t            ctl;

    assign raw_key = s_tdata[65:2];
    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Keep the low KEY_BYTES bytes, drop everything after the first zero byte.
    always_comb
    begin
        logic       alive;
        logic [7:0] byte_v;
        norm_key = '0;
        alive    = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            byte_v = raw_key[8*(KEY_BYTES-1-b) +: 8];
            if (byte_v == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                norm_key[8*(KEY_BYTES-1-b) +: 8] = byte_v;
            end
        end
    end

    // Hold the command until the row has executed it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tdata[1:0];
            key_reg   <= norm_key;
            value_reg <= s_tdata[97:66];
        end
    end

    assign go        = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign empty_key = (key_reg == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // Decide the outcome from the parallel compare of all cells.
    always_comb
    begin
        status       = ST_NOT_FOUND;
        result_value = '0;
        ctl          = '0;
        count_next   = count_reg;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (empty_key)
                    status = ST_EMPTY;
                else if (hit)
                    status = ST_DUPLICATE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    status     = ST_OK;
                    ctl.ins    = go;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty_key)
                    status = ST_EMPTY;
                else if (hit)
                begin
                    status     = ST_OK;
                    ctl.rem    = go;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                if (empty_key)
                    status = ST_EMPTY;
                else if (hit)
                begin
                    status       = ST_OK;
                    result_value = hit_value;
                end
            end
            default:
            begin
                status = ST_NOT_FOUND;
            end
        endcase
    end

    skvt_chain #(
        .CAPACITY(CAPACITY),
        .KEY_W   (KEY_W),
        .CNT_W   (CNT_W)
    ) u_chain (
        .clk      (clk),
        .ctl      (ctl),
        .key_in   (key_reg),
        .value_in (value_reg),
        .count    (count_reg),
        .hit      (hit),
        .value_out(hit_value)
    );

    // Sequencer: capture, then execute once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_status_reg <= status;
            out_value_reg  <= result_value;
            out_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_value_reg, out_status_reg};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.rem))
        else $error("insert and remove shift in the same cycle");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance the count");

    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rem |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not drop the count");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_EXEC)
        else $error("result word without an executed command");

endmodule

// ----- tb/sorted_key_value_table_tb.sv -----
// Self-checking testbench for the sorted key/value table: directed and random traffic.
module sorted_key_value_table_tb;

    import skvt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BYTES   = 8;
    localparam int POOL_SIZE   = 80;
    localparam int CYCLE_LIMIT = 300000;

    // Command code outside the defined set; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  value_out;
        logic [COUNT_W-1:0]  count;
    } table_reply_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;     // command[1:0], key[65:2], value[97:66], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;     // status[2:0], value_out[34:3], count[41:35], zero pad

    // Result word fields
    logic [STATUS_W-1:0] reply_status;
    logic [VALUE_W-1:0]  reply_value;
    logic [COUNT_W-1:0]  reply_count;

    assign reply_status = m_tdata[2:0];
    assign reply_value  = m_tdata[34:3];
    assign reply_count  = m_tdata[41:35];

    // Shadow copy of the table, kept sorted the same way as the block
    logic [KEY_MAXW-1:0] stored_keys[$];
    logic [VALUE_W-1:0]  stored_vals[$];

    // Replies predicted at acceptance, oldest first
    table_reply_t pending_replies[$];

    // Key pool: short strings over a tiny alphabet, so inserts collide and lookups hit
    logic [KEY_MAXW-1:0] key_pool[POOL_SIZE];
    int                  key_len[POOL_SIZE];

    int send_idle_pct;
    int ready_stall_pct;
    int error_count;
    int words_sent;
    int peak_fill;
    int status_tally[5];
    int cycle_count;

    sorted_key_value_table #(
        .CAPACITY  (TABLE_DEPTH),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Keep the low KEY_BYTES bytes and cut the string at its first zero byte.
    function automatic logic [KEY_MAXW-1:0] clean_key(input logic [KEY_MAXW-1:0] raw);
        logic [KEY_MAXW-1:0] k;
        logic                ended;
        k = '0;
        ended = 1'b0;
        for (int i = KEY_BYTES - 1; i >= 0; i--)
        begin
            if (raw[8*i +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    // Apply one command to the shadow table and return the reply it must produce.
    function automatic table_reply_t apply_table_op(input logic [CMD_W-1:0]    op,
                                                    input logic [KEY_MAXW-1:0] raw_key,
                                                    input logic [VALUE_W-1:0]  val);
        table_reply_t        r;
        logic [KEY_MAXW-1:0] k;
        int                  pos;
        bit                  hit;
        k = clean_key(raw_key);
        r.status = ST_NOT_FOUND;
        r.value_out = '0;
        // First slot whose key is not below k
        pos = 0;
        while (pos < stored_keys.size() && stored_keys[pos] < k)
            pos++;
        hit = (pos < stored_keys.size()) && (stored_keys[pos] == k);
        if (op != CMD_UNUSED && k == '0)
            r.status = ST_EMPTY;
        else if (op == CMD_INSERT)
        begin
            // Duplicate wins over full
            if (hit)
                r.status = ST_DUPLICATE;
            else if (stored_keys.size() >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                stored_keys.insert(pos, k);
                stored_vals.insert(pos, val);
                r.status = ST_OK;
            end
        end
        else if (op == CMD_REMOVE)
        begin
            if (hit)
            begin
                stored_keys.delete(pos);
                stored_vals.delete(pos);
                r.status = ST_OK;
            end
        end
        else if (op == CMD_LOOKUP)
        begin
            if (hit)
            begin
                r.value_out = stored_vals[pos];
                r.status = ST_OK;
            end
        end
        r.count = COUNT_W'(stored_keys.size());
        status_tally[int'(r.status)]++;
        if (stored_keys.size() > peak_fill)
            peak_fill = stored_keys.size();
        return r;
    endfunction

    // Result side: random backpressure, compare each result word with the oldest prediction.
    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (reply_status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, reply_status);
                        error_count++;
                    end
                    if (reply_value !== want.value_out)
                    begin
                        $error("value_out: expected %h, got %h", want.value_out, reply_value);
                        error_count++;
                    end
                    if (reply_count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, reply_count);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Send one command word, idling at random first; predict its reply once accepted.
    task automatic send_word(input logic [CMD_W-1:0]    op,
                             input logic [KEY_MAXW-1:0] raw_key,
                             input logic [VALUE_W-1:0]  val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, raw_key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_replies.push_back(apply_table_op(op, raw_key, val));
        words_sent++;
    endtask

    // Hold the input idle until every predicted reply has come back.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_key_pool();
        logic [KEY_MAXW-1:0] k;
        logic [7:0]          b;
        int                  len;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            len = $urandom_range(KEY_BYTES, 1);
            k = '0;
            for (int j = 0; j < len; j++)
            begin
                case ($urandom_range(5))
                    0: b = 8'h01;
                    1: b = 8'hFF;
                    default: b = 8'h60 + 8'($urandom_range(3, 1));
                endcase
                k[8*(KEY_BYTES-1-j) +: 8] = b;
            end
            key_pool[i] = k;
            key_len[i]  = len;
        end
    endtask

    // Pick a pool key; sometimes fill the bytes past its terminator with junk.
    function automatic logic [KEY_MAXW-1:0] pick_pool_key();
        logic [KEY_MAXW-1:0] k;
        int                  idx;
        int                  term;
        idx = $urandom_range(POOL_SIZE - 1);
        k = key_pool[idx];
        if (key_len[idx] < KEY_BYTES - 1 && $urandom_range(2) == 0)
        begin
            term = KEY_BYTES - 1 - key_len[idx];
            for (int j = 0; j < term; j++)
                k[8*j +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    // Lookup and remove on a freshly reset table.
    task automatic test_empty_table();
        send_word(CMD_LOOKUP, 64'h6162_6300_0000_0000, 32'hDEAD_BEEF);
        send_word(CMD_REMOVE, 64'h0100_0000_0000_0000, 32'h0);
        wait_for_replies();
    endtask

    // A zero first byte makes the key empty, whatever follows it.
    task automatic test_empty_keys();
        send_word(CMD_INSERT, 64'h0, 32'hFFFF_FFFF);
        send_word(CMD_REMOVE, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
        send_word(CMD_LOOKUP, 64'h00AB_CDEF_0123_4567, 32'h5555_AAAA);
        // Unused command is not refused as empty
        send_word(CMD_UNUSED, 64'h0, 32'h0);
        wait_for_replies();
    endtask

    // Key and value extremes, duplicates, a key with junk after its end, unused command.
    task automatic test_single_entries();
        send_word(CMD_INSERT, 64'h0100_0000_0000_0000, 32'h0000_0000);
        send_word(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 64'h6162_6300_0000_0000, 32'h0000_1234);
        send_word(CMD_INSERT, 64'h6162_6300_0000_0000, 32'h0000_9999);
        send_word(CMD_LOOKUP, 64'h6162_6300_DEAD_BEEF, 32'h0);
        send_word(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_word(CMD_LOOKUP, 64'h0100_0000_0000_0000, 32'h0);
        send_word(CMD_LOOKUP, 64'h6162_6400_0000_0000, 32'h0);
        send_word(CMD_REMOVE, 64'h6162_6300_0000_0000, 32'h0);
        send_word(CMD_LOOKUP, 64'h6162_6300_0000_0000, 32'h0);
        send_word(CMD_REMOVE, 64'h6162_6300_0000_0000, 32'h0);
        send_word(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_REMOVE, 64'h0100_0000_0000_0000, 32'h0);
        send_word(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        wait_for_replies();
    endtask

    // Random traffic in stretches that alternately favour inserts, to fill the table, and removes, to drain it.
    task automatic test_mixed_traffic(input int words, input int idle_pct, input int stall_pct);
        int                  roll;
        int                  ins_pct;
        int                  rem_pct;
        logic [CMD_W-1:0]    op;
        logic [KEY_MAXW-1:0] k;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        for (int n = 0; n < words; n++)
        begin
            if ((n / 128) % 2 == 0)
            begin
                ins_pct = 60;
                rem_pct = 14;
            end
            else
            begin
                ins_pct = 14;
                rem_pct = 56;
            end
            roll = $urandom_range(99);
            k = pick_pool_key();
            if (roll < 6)
            begin
                // Noise: unused command, raw random keys, empty keys
                case ($urandom_range(2))
                    0: op = CMD_UNUSED;
                    1:
                    begin
                        op = CMD_W'($urandom_range(3));
                        k  = {$urandom, $urandom};
                    end
                    default:
                    begin
                        op = CMD_W'($urandom_range(2));
                        k  = {8'd0, 24'($urandom), $urandom};
                    end
                endcase
            end
            else if (roll < 6 + ins_pct)
                op = CMD_INSERT;
            else if (roll < 6 + ins_pct + rem_pct)
                op = CMD_REMOVE;
            else
                op = CMD_LOOKUP;
            send_word(op, k, $urandom);
            // Now and then let the table settle completely
            if ($urandom_range(99) == 0)
                wait_for_replies();
        end
        wait_for_replies();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        send_idle_pct   = 35;
        ready_stall_pct = 67;
        error_count     = 0;
        words_sent      = 0;
        peak_fill       = 0;
        cycle_count     = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        build_key_pool();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_empty_keys();
        test_single_entries();
        test_mixed_traffic(616, 35, 67);
        test_mixed_traffic(616, 67, 35);
        test_mixed_traffic(618, 0, 0);

        // Hold off a little longer to catch stray result words
        wait_for_replies();
        repeat (20) @(posedge clk);

        $display("tb: %0d words: %0d ok, %0d not found, %0d duplicate, %0d full, %0d empty key",
                 words_sent, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
                 status_tally[ST_DUPLICATE], status_tally[ST_FULL], status_tally[ST_EMPTY]);
        $display("tb: table peaked at %0d entries, %0d mismatches", peak_fill, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sorted_key_value_table.f -----
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_cell.sv
hw/rtl/skvt_chain.sv
hw/rtl/sorted_key_value_table.sv
tb/sorted_key_value_table_tb.sv
